[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, muted during reset
`define NTLE_ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, muted during reset
`define NTLE_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

[hdl/ntle_pkg.sv]
// ----------------------------------------------------------------------------
// ntle_pkg
// Types, codes and sizes shared by the neighbor table blocks.
// ----------------------------------------------------------------------------
package ntle_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
   localparam int COUNT_W       = SLOT_W + 1;
   localparam int KEY_W         = 32;
   localparam int TIME_W        = 32;
   localparam int OP_W          = 3;
   localparam int ENTRY_W       = KEY_W + TIME_W;

   localparam logic [OP_W-1:0] OP_TOUCH  = 3'd0;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd1;
   localparam logic [OP_W-1:0] OP_PRUNE  = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
   localparam logic [OP_W-1:0] OP_NAMED  = 3'd5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_NAMED   = 1'b0;
   localparam logic CSR_IDX_UNNAMED = 1'b1;

   localparam logic [TIME_W-1:0] EXPIRY_NAMED_RESET   = 32'd86400;
   localparam logic [TIME_W-1:0] EXPIRY_UNNAMED_RESET = 32'd3600;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [KEY_W-1:0]  node_number;
      logic [TIME_W-1:0] now;
      logic [5:0]        slot;
      logic              named_value;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] found_slot;
      logic       slot_valid;
      logic       evicted;
      logic [6:0] removed_count;
      logic [6:0] high_water;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic scan_rd;
      logic commit;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } status_type;

endpackage

[hdl/neighbor_table_lru_expiry.sv]
// Touch, find and prune: after accept, 64 reads on the one entry RAM read
// port, one drain, one commit and one output load, which waits while a held
// response is stalled; the next word is accepted once the block is idle again.
// Remove, clear and set named: one commit, then the output load.
// Reset empties the table at once (valid bits and high water are flops, no
// clearing pass) and loads the expiry limits with 86400 and 3600 seconds.
// ----------------------------------------------------------------------------
// neighbor_table_lru_expiry
// Neighbor table with least-recently-heard replacement and age expiry,
// with an APB-style register port for the two expiry limits.
// ----------------------------------------------------------------------------
module neighbor_table_lru_expiry (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ntle_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ntle_pkg::rsp_type                 rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ntle_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ntle_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ntle_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import ntle_pkg::*;

   logic [TIME_W-1:0] expiry_named_ff, expiry_named_in;
   logic [TIME_W-1:0] expiry_unnamed_ff, expiry_unnamed_in;
   logic              csr_wr;
   logic              csr_idx;
   cmd_type           cmd;
   status_type        status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[2];

   always_comb begin
      expiry_named_in   = expiry_named_ff;
      expiry_unnamed_in = expiry_unnamed_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_IDX_NAMED:   expiry_named_in   = csr_pwdata;
            CSR_IDX_UNNAMED: expiry_unnamed_in = csr_pwdata;
            default:         expiry_named_in   = expiry_named_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_IDX_NAMED:   csr_prdata = expiry_named_ff;
         CSR_IDX_UNNAMED: csr_prdata = expiry_unnamed_ff;
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expiry_named_ff   <= EXPIRY_NAMED_RESET;
         expiry_unnamed_ff <= EXPIRY_UNNAMED_RESET;
      end else begin
         expiry_named_ff   <= expiry_named_in;
         expiry_unnamed_ff <= expiry_unnamed_in;
      end
   end

   ntle_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op   (req_data.operation),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   ntle_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_data          (req_data),
      .cfg_expiry_named  (expiry_named_ff),
      .cfg_expiry_unnamed(expiry_unnamed_ff),
      .cmd               (cmd),
      .status            (status),
      .rsp_data          (rsp_data)
   );

endmodule

[hdl/ntle_ram.sv]
// ----------------------------------------------------------------------------
// ntle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ntle_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/ntle_ctrl.sv]
// ----------------------------------------------------------------------------
// ntle_ctrl
// Sequencer: accepts a request word, runs the table scan, commits the update
// and hands the response word to the output register.
// ----------------------------------------------------------------------------
module ntle_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [ntle_pkg::OP_W-1:0] req_op,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  ntle_pkg::status_type   status,
   output ntle_pkg::cmd_type      cmd
);
   import ntle_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.start = 1'b1;
               if (req_op == OP_TOUCH || req_op == OP_FIND || req_op == OP_PRUNE) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_COMMIT;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last read word is evaluated in this cycle
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/ntle_dp.sv]
// ----------------------------------------------------------------------------
// ntle_dp
// Datapath: entry RAM (key, last heard), valid and named bits, scan
// trackers for match, free slot and oldest entry, prune compare and the
// response registers.
// ----------------------------------------------------------------------------
module ntle_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  ntle_pkg::req_type           req_data,
   input  logic [ntle_pkg::TIME_W-1:0] cfg_expiry_named,
   input  logic [ntle_pkg::TIME_W-1:0] cfg_expiry_unnamed,
   input  ntle_pkg::cmd_type           cmd,
   output ntle_pkg::status_type        status,
   output ntle_pkg::rsp_type           rsp_data
);
   import ntle_pkg::*;

   req_type                req_ff, req_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [TABLE_ENTRIES-1:0] named_ff, named_in;
   logic [COUNT_W-1:0]     used_extent_ff, used_extent_in;
   logic [SLOT_W-1:0]      cnt_ff, cnt_in;
   logic [SLOT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                   rd_live_ff, rd_live_in;
   logic                   match_found_ff, match_found_in;
   logic [SLOT_W-1:0]      match_idx_ff, match_idx_in;
   logic                   free_found_ff, free_found_in;
   logic [SLOT_W-1:0]      free_idx_ff, free_idx_in;
   logic [TIME_W-1:0]      min_heard_ff, min_heard_in;
   logic [SLOT_W-1:0]      min_idx_ff, min_idx_in;
   logic [COUNT_W-1:0]     removed_ff, removed_in;
   rsp_type                res_ff, res_in;
   rsp_type                rsp_ff, rsp_in;

   logic [ENTRY_W-1:0]     ram_rd_data;
   logic                   ram_we;
   logic [SLOT_W-1:0]      ram_waddr;
   logic [ENTRY_W-1:0]     ram_wdata;

   logic                   ev_valid;
   logic [KEY_W-1:0]       ev_key;
   logic [TIME_W-1:0]      ev_heard;
   logic [TIME_W-1:0]      ev_limit;
   logic [TIME_W-1:0]      ev_age;
   logic                   ev_expire;
   logic                   is_lookup;
   logic [SLOT_W-1:0]      pick;
   logic                   slot_ok;

   ntle_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (cmd.scan_rd),
      .rd_addr(cnt_ff),
      .rd_data(ram_rd_data)
   );

   assign status.scan_last = (cnt_ff == SLOT_W'(TABLE_ENTRIES - 1));

   // evaluation of the word read in the previous cycle
   assign ev_valid  = valid_ff[rd_idx_ff];
   assign ev_key    = ram_rd_data[ENTRY_W-1:TIME_W];
   assign ev_heard  = ram_rd_data[TIME_W-1:0];
   assign ev_limit  = named_ff[rd_idx_ff] ? cfg_expiry_named : cfg_expiry_unnamed;
   assign ev_age    = req_ff.now - ev_heard;
   assign ev_expire = (req_ff.operation == OP_PRUNE) && ev_valid &&
                      (req_ff.now >= ev_heard) && (ev_age > ev_limit);
   assign is_lookup = (req_ff.operation == OP_TOUCH) || (req_ff.operation == OP_FIND);

   assign pick    = match_found_ff ? match_idx_ff :
                    (free_found_ff ? free_idx_ff : min_idx_ff);
   assign slot_ok = ({1'b0, req_ff.slot} < COUNT_W'(TABLE_ENTRIES));

   assign ram_we    = cmd.commit && (req_ff.operation == OP_TOUCH);
   assign ram_waddr = pick;
   assign ram_wdata = {req_ff.node_number, req_ff.now};

   always_comb begin
      req_in         = req_ff;
      valid_in       = valid_ff;
      named_in       = named_ff;
      used_extent_in = used_extent_ff;
      cnt_in         = cnt_ff;
      rd_idx_in      = rd_idx_ff;
      rd_live_in     = cmd.scan_rd;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      min_heard_in   = min_heard_ff;
      min_idx_in     = min_idx_ff;
      removed_in     = removed_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;

      if (cmd.start) begin
         req_in         = req_data;
         cnt_in         = '0;
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         removed_in     = '0;
      end

      if (cmd.scan_rd) begin
         rd_idx_in = cnt_ff;
         cnt_in    = cnt_ff + 1'b1;
      end

      if (rd_live_ff) begin
         if (is_lookup && ev_valid && ev_key == req_ff.node_number && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = rd_idx_ff;
         end
         if (!ev_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
         // strict less keeps the lowest index on ties
         if (rd_idx_ff == '0 || ev_heard < min_heard_ff) begin
            min_heard_in = ev_heard;
            min_idx_in   = rd_idx_ff;
         end
         if (ev_expire) begin
            valid_in[rd_idx_ff] = 1'b0;
            removed_in          = removed_ff + 1'b1;
         end
      end

      if (cmd.commit) begin
         res_in = '0;
         unique case (req_ff.operation)
            OP_TOUCH: begin
               res_in.hit        = match_found_ff;
               res_in.found_slot = pick;
               res_in.slot_valid = 1'b1;
               if (!match_found_ff) begin
                  valid_in[pick] = 1'b1;
                  named_in[pick] = 1'b0;
                  if (free_found_ff) begin
                     if ({1'b0, free_idx_ff} >= used_extent_ff) begin
                        used_extent_in = {1'b0, free_idx_ff} + 1'b1;
                     end
                  end else begin
                     res_in.evicted = 1'b1;
                  end
               end
            end
            OP_FIND: begin
               res_in.hit        = match_found_ff;
               res_in.slot_valid = match_found_ff;
               res_in.found_slot = match_found_ff ? match_idx_ff : '0;
            end
            OP_PRUNE: begin
               res_in.removed_count = removed_ff;
            end
            OP_REMOVE: begin
               if (slot_ok) begin
                  valid_in[req_ff.slot] = 1'b0;
               end
            end
            OP_CLEAR: begin
               valid_in       = '0;
               used_extent_in = '0;
            end
            OP_NAMED: begin
               if (slot_ok && valid_ff[req_ff.slot]) begin
                  named_in[req_ff.slot] = req_ff.named_value;
               end
            end
            default: begin
               // unused operation codes leave the table alone
            end
         endcase
         res_in.high_water = used_extent_in;
      end

      if (cmd.load_rsp) begin
         rsp_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         named_ff       <= '0;
         used_extent_ff <= '0;
         rd_live_ff     <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         named_ff       <= named_in;
         used_extent_ff <= used_extent_in;
         rd_live_ff     <= rd_live_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      cnt_ff         <= cnt_in;
      rd_idx_ff      <= rd_idx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      min_heard_ff   <= min_heard_in;
      min_idx_ff     <= min_idx_in;
      removed_ff     <= removed_in;
      res_ff         <= res_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

[hdl/ntle_checker.sv]
// ----------------------------------------------------------------------------
// ntle_checker
// Port-level checks on the neighbor table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntle_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ntle_pkg::rsp_type rsp_data
);
   import ntle_pkg::*;

   // held response word stays put
   `NTLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response word changed")

   // one word in flight: busy right after an accept
   `NTLE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "request accepted while a word is in flight")

   // eviction only from a completely claimed table
   `NTLE_ASSERT_IMPLY(a_evict_full, clock, reset, rsp_valid && rsp_data.evicted, rsp_data.slot_valid && !rsp_data.hit && rsp_data.high_water == COUNT_W'(TABLE_ENTRIES), "eviction from a table that is not full")

   // a hit names a slot below the high water mark
   `NTLE_ASSERT_IMPLY(a_hit_in_extent, clock, reset, rsp_valid && rsp_data.hit, rsp_data.slot_valid && ({1'b0, rsp_data.found_slot} < rsp_data.high_water), "hit slot outside the claimed extent")

endmodule

bind neighbor_table_lru_expiry ntle_checker u_ntle_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
